// ===== hw/rtl/ifd_pkg.sv =====
// ifd_pkg: shared types, constants and float helpers of the int to fp16 dequantizer.
// Used by ifd_bias_mem, ifd_mul, ifd_add and int_to_fp16_dequantizer.
// No dependencies.
package ifd_pkg;

	localparam int MAX_BIAS_DEF = 64;
	localparam int POS_W = 6;
	localparam int LEN_W = 7;
	localparam int EXP_W = 10;
	localparam int MANT_W = 48;
	localparam int MUL_STAGES = 6;
	localparam int ADD_STAGES = 5;
	localparam int STAGES = MUL_STAGES + ADD_STAGES;
	localparam logic [15:0] QNAN_H = 16'h7E00;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_RECIP = 2'd1;
	localparam logic [1:0] REG_BIAS_LEN = 2'd2;

	// value = mant (MSB is the leading one) * 2^(ex - MANT_W + 1)
	typedef struct packed {
		logic zero;
		logic inf;
		logic signed [EXP_W-1:0] ex;
		logic [MANT_W-1:0] mant;
	} ifd_num_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic start;
		logic wide;
	} ifd_mreq_t;

	function automatic logic [6:0] lzc64(input logic [63:0] x);
		logic [6:0] n;
		logic hit;
		n = 7'd64;
		hit = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!hit && x[i]) begin
				n = 7'(63 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	// Round a normalized magnitude to prec bits, gradual underflow below emin,
	// nearest-even, overflow past emax to infinity.
	function automatic ifd_num_t round_num(input logic [MANT_W-1:0] mant,
		input logic signed [EXP_W-1:0] ex, input int prec, input int emin, input int emax);
		ifd_num_t r;
		int k;
		int sh;
		int e_new;
		logic [MANT_W:0] kept;
		logic [MANT_W-1:0] rem;
		logic [MANT_W-1:0] halfv;
		logic [MANT_W-1:0] lowm;
		logic up;
		r.zero = 1'b0;
		r.inf = 1'b0;
		r.ex = ex;
		r.mant = mant;
		kept = '0;
		rem = '0;
		halfv = '0;
		lowm = '0;
		up = 1'b0;
		sh = 0;
		e_new = int'(ex);
		k = (int'(ex) >= emin) ? prec : prec - (emin - int'(ex));
		if (k < 0) begin
			r.zero = 1'b1;
		end else if (k == 0) begin
			// leading one sits exactly at the half point: round up on any tail
			if (|mant[MANT_W-2:0]) begin
				r.mant = {1'b1, {(MANT_W-1){1'b0}}};
				r.ex = EXP_W'(emin - prec + 1);
			end else begin
				r.zero = 1'b1;
			end
		end else begin
			sh = MANT_W - k;
			kept = (MANT_W+1)'(mant >> sh);
			lowm = (MANT_W'(1) << sh) - MANT_W'(1);
			rem = mant & lowm;
			halfv = MANT_W'(1) << (sh - 1);
			up = (rem > halfv) || (rem == halfv && kept[0]);
			kept = kept + (MANT_W+1)'(up);
			if (kept == ((MANT_W+1)'(1) << k)) begin
				e_new = int'(ex) + 1;
				r.mant = {1'b1, {(MANT_W-1){1'b0}}};
			end else begin
				r.mant = MANT_W'(kept << sh);
			end
			if (e_new > emax) begin
				r.inf = 1'b1;
			end
			r.ex = EXP_W'(e_new);
		end
		return r;
	endfunction

	// Pack a value already rounded to half precision.
	function automatic logic [15:0] pack_half(input logic sign, input logic nan,
		input ifd_num_t n);
		logic [15:0] h;
		logic [10:0] m11;
		int sh;
		m11 = n.mant[MANT_W-1 -: 11];
		sh = -14 - int'(n.ex);
		if (nan) begin
			h = QNAN_H;
		end else if (n.inf) begin
			h = {sign, 5'h1f, 10'h0};
		end else if (n.zero) begin
			h = {sign, 15'h0};
		end else if (sh <= 0) begin
			h = {sign, 5'(int'(n.ex) + 15), m11[9:0]};
		end else begin
			h = {sign, 5'h0, 10'(m11 >> sh)};
		end
		return h;
	endfunction

	// Magnitude of a finite half in units of 2^-24.
	function automatic logic [40:0] half_fix(input logic [15:0] h);
		logic [40:0] v;
		if (h[14:10] == 5'h0) begin
			v = 41'(h[9:0]);
		end else begin
			v = 41'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
		end
		return v;
	endfunction

endpackage

// ===== hw/rtl/int_to_fp16_dequantizer.sv =====
// int_to_fp16_dequantizer: top level, config registers and pipeline flow control.
// Depends on ifd_pkg, ifd_bias_mem, ifd_mul and ifd_add.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_ready | kind, sample, start_req, entry_index, entry_value
//   out     | out_valid/out_ready | half_result
//   cfg     | cfg_we              | cfg_index, cfg_data
//
// One transaction per cycle while in_ready is high; bias table writes give no result.
// Reset clears valids, position and config, except that the recip scale resets to 1.0.
// The bias table is a 1-read/1-write memory read at accept; position updates at accept.
// Each stage advances when empty or when the stage after it moves, so a stalled
// output fills bubbles before in_ready drops.
module int_to_fp16_dequantizer #(
	parameter int MAX_BIAS = ifd_pkg::MAX_BIAS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [31:0] sample,
	input  logic               start_req,
	input  logic [5:0]         entry_index,
	input  logic [15:0]        entry_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        half_result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int N = ifd_pkg::STAGES;

	logic input_format_q;
	logic [31:0] recip_scale_q;
	logic [ifd_pkg::LEN_W-1:0] bias_len_q;
	logic [ifd_pkg::LEN_W-1:0] len;
	logic use_bias;
	logic [N-1:0] vld_q;
	logic [N-1:0] adv;
	logic data_acc;
	ifd_pkg::ifd_mreq_t mreq;
	logic [15:0] bias_rd;
	logic [15:0] half_s6;
	logic [15:0] bias_s6;
	logic ub_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_format_q <= 1'b0;
			recip_scale_q <= 32'h3f80_0000;
			bias_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ifd_pkg::REG_FORMAT: input_format_q <= cfg_data[0];
				ifd_pkg::REG_RECIP: recip_scale_q <= cfg_data;
				ifd_pkg::REG_BIAS_LEN: bias_len_q <= cfg_data[ifd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len = (32'(bias_len_q) > 32'(MAX_BIAS)) ? ifd_pkg::LEN_W'(MAX_BIAS) : bias_len_q;
		use_bias = input_format_q && (len != '0);
		adv[N-1] = !vld_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
		in_ready = adv[0];
		data_acc = in_valid && in_ready && kind;
		mreq.wr = in_valid && in_ready && !kind;
		mreq.rd = data_acc;
		mreq.start = start_req;
		mreq.wide = input_format_q;
	end

	// advance valids through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= data_acc;
			end
			for (int k = 1; k < N; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	ifd_bias_mem #(
		.MAX_BIAS(MAX_BIAS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mreq),
		.wr_index (entry_index),
		.wr_value (entry_value),
		.len      (len),
		.bias_s1  (bias_rd)
	);

	ifd_mul u_mul (
		.clk      (clk),
		.adv      (adv[ifd_pkg::MUL_STAGES-1:0]),
		.sample   (sample),
		.wide     (input_format_q),
		.use_bias (use_bias),
		.recip    (recip_scale_q),
		.bias_rd  (bias_rd),
		.half_s6  (half_s6),
		.bias_s6  (bias_s6),
		.ub_s6    (ub_s6)
	);

	ifd_add u_add (
		.clk     (clk),
		.adv     (adv[N-1:ifd_pkg::MUL_STAGES]),
		.half_s6 (half_s6),
		.bias_s6 (bias_s6),
		.ub_s6   (ub_s6),
		.res_s11 (half_result)
	);

	assign out_valid = vld_q[N-1];

`ifndef SYNTHESIS
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_q[0] && out_valid && !out_ready)
		else $error("input stalled with room in the pipeline");
	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && half_result[14:10] == 5'h1f && half_result[9:0] != 10'h0
		|-> half_result == ifd_pkg::QNAN_H)
		else $error("non-canonical NaN on output");
`endif

endmodule

// ===== hw/rtl/ifd_bias_mem.sv =====
// ifd_bias_mem: bias table memory and the cyclic bias position.
// Depends on ifd_pkg.
module ifd_bias_mem #(
	parameter int MAX_BIAS = ifd_pkg::MAX_BIAS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ifd_pkg::ifd_mreq_t         req,
	input  logic [5:0]                 wr_index,
	input  logic [15:0]                wr_value,
	input  logic [ifd_pkg::LEN_W-1:0]  len,
	output logic [15:0]                bias_s1
);

	localparam int AW = (MAX_BIAS > 1) ? $clog2(MAX_BIAS) : 1;

	logic [15:0] mem [MAX_BIAS];
	logic [ifd_pkg::POS_W-1:0] pos_q;
	logic [ifd_pkg::POS_W-1:0] pos_base;
	logic [ifd_pkg::POS_W-1:0] pos_cur;
	logic [ifd_pkg::LEN_W-1:0] pos_nxt;
	logic wr_ok;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	always_comb begin
		pos_base = req.start ? '0 : pos_q;
		pos_cur = (ifd_pkg::LEN_W'(pos_base) < len) ? pos_base : '0;
		pos_nxt = ifd_pkg::LEN_W'(pos_cur) + 1'b1;
		wr_ok = req.wr && (32'(wr_index) < 32'(MAX_BIAS));
		waddr = AW'(wr_index);
		raddr = AW'(pos_cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (req.rd) begin
			if (req.wide && len != '0) begin
				pos_q <= (pos_nxt >= len) ? '0 : pos_nxt[ifd_pkg::POS_W-1:0];
			end else if (req.start) begin
				pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[waddr] <= wr_value;
		end
		if (req.rd) begin
			bias_s1 <= mem[raddr];
		end
	end

`ifndef SYNTHESIS
	a_no_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr && req.rd)) else $error("bias table write and read in one cycle");
	a_pos_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd && req.wide && len != '0 |=> ifd_pkg::LEN_W'(pos_q) < $past(len))
		else $error("bias position left the table length");
`endif

endmodule

// ===== hw/rtl/ifd_mul.sv =====
// ifd_mul: integer to float, scale multiply and rounding to half (stages 1 to 6).
// Depends on ifd_pkg.
module ifd_mul (
	input  logic                          clk,
	input  logic [ifd_pkg::MUL_STAGES-1:0] adv,
	input  logic signed [31:0]            sample,
	input  logic                          wide,
	input  logic                          use_bias,
	input  logic [31:0]                   recip,
	input  logic [15:0]                   bias_rd,
	output logic [15:0]                   half_s6,
	output logic [15:0]                   bias_s6,
	output logic                          ub_s6
);

	logic [31:0] val;
	logic [23:0] rsig;
	logic [6:0] lz_c;
	logic [6:0] rlz_c;
	logic [31:0] mag_s1, mag_s2;
	logic sgn_s1, sgn_s2, sgn_s3;
	logic wide_s1, wide_s2, wide_s3, wide_s4, wide_s5;
	logic ub_s1, ub_s2, ub_s3, ub_s4, ub_s5;
	logic [15:0] bias_s2, bias_s3, bias_s4, bias_s5;
	logic [4:0] lz_s2, rlz_s2;
	ifd_pkg::ifd_num_t a_c, b_c, b_r, a_s3, b_s3;
	logic bsgn_s3, bnan_s3;
	logic [47:0] prod_s4;
	logic signed [ifd_pkg::EXP_W-1:0] e_s4;
	logic sgn_s4, nan_s4, inf_s4, zero_s4;
	ifd_pkg::ifd_num_t n5_c, n5_s5, n6_c;
	logic [47:0] m5;
	logic signed [ifd_pkg::EXP_W-1:0] e5;
	logic sgn_s5, nan_s5;

	always_comb begin
		val = wide ? sample : {{24{sample[7]}}, sample[7:0]};
		rsig = {|recip[30:23], recip[22:0]};
		lz_c = ifd_pkg::lzc64({mag_s1, 32'h0});
		rlz_c = ifd_pkg::lzc64({rsig, 40'h0});
	end

	// stage 1: sign and magnitude
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sgn_s1 <= val[31];
			mag_s1 <= val[31] ? (32'd0 - val) : val;
			wide_s1 <= wide;
			ub_s1 <= use_bias;
		end
	end

	// stage 2: leading zero counts
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mag_s2 <= mag_s1;
			sgn_s2 <= sgn_s1;
			wide_s2 <= wide_s1;
			ub_s2 <= ub_s1;
			bias_s2 <= bias_rd;
			lz_s2 <= lz_c[4:0];
			rlz_s2 <= rlz_c[4:0];
		end
	end

	// stage 3: normalize, sample to single, scale to half in int8 mode
	always_comb begin
		a_c = ifd_pkg::round_num({mag_s2 << lz_s2, 16'h0},
			ifd_pkg::EXP_W'(31 - int'(lz_s2)), 24, -126, 127);
		a_c.zero = (mag_s2 == 32'h0);
		a_c.inf = 1'b0;
		b_c.zero = (recip[30:0] == 31'h0);
		b_c.inf = (recip[30:23] == 8'hff);
		b_c.mant = {rsig << rlz_s2, 24'h0};
		b_c.ex = ifd_pkg::EXP_W'(((recip[30:23] == 8'h0) ? -126 : int'(recip[30:23]) - 127)
			- int'(rlz_s2));
		b_r = b_c;
		if (!wide_s2 && !b_c.zero && !b_c.inf) begin
			b_r = ifd_pkg::round_num(b_c.mant, b_c.ex, 11, -14, 15);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			a_s3 <= a_c;
			b_s3 <= b_r;
			bsgn_s3 <= recip[31];
			bnan_s3 <= (recip[30:23] == 8'hff) && (recip[22:0] != 23'h0);
			sgn_s3 <= sgn_s2;
			wide_s3 <= wide_s2;
			ub_s3 <= ub_s2;
			bias_s3 <= bias_s2;
		end
	end

	// stage 4: significand multiply
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			prod_s4 <= a_s3.mant[47:24] * b_s3.mant[47:24];
			e_s4 <= ifd_pkg::EXP_W'(int'(a_s3.ex) + int'(b_s3.ex));
			sgn_s4 <= sgn_s3 ^ bsgn_s3;
			nan_s4 <= bnan_s3 || (b_s3.inf && a_s3.zero);
			inf_s4 <= b_s3.inf && !a_s3.zero;
			zero_s4 <= a_s3.zero || b_s3.zero;
			wide_s4 <= wide_s3;
			ub_s4 <= ub_s3;
			bias_s4 <= bias_s3;
		end
	end

	// stage 5: first rounding (single in int32 mode, half in int8 mode)
	always_comb begin
		m5 = prod_s4[47] ? prod_s4 : {prod_s4[46:0], 1'b0};
		e5 = prod_s4[47] ? e_s4 + 1'b1 : e_s4;
		n5_c = wide_s4 ? ifd_pkg::round_num(m5, e5, 24, -126, 127)
			: ifd_pkg::round_num(m5, e5, 11, -14, 15);
		if (inf_s4) begin
			n5_c.inf = 1'b1;
			n5_c.zero = 1'b0;
		end else if (zero_s4) begin
			n5_c.zero = 1'b1;
			n5_c.inf = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			n5_s5 <= n5_c;
			sgn_s5 <= sgn_s4;
			nan_s5 <= nan_s4;
			wide_s5 <= wide_s4;
			ub_s5 <= ub_s4;
			bias_s5 <= bias_s4;
		end
	end

	// stage 6: second rounding to half in int32 mode, pack
	always_comb begin
		n6_c = n5_s5;
		if (wide_s5 && !n5_s5.zero && !n5_s5.inf) begin
			n6_c = ifd_pkg::round_num(n5_s5.mant, n5_s5.ex, 11, -14, 15);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			half_s6 <= ifd_pkg::pack_half(sgn_s5, nan_s5, n6_c);
			ub_s6 <= ub_s5;
			bias_s6 <= bias_s5;
		end
	end

endmodule

// ===== hw/rtl/ifd_add.sv =====
// ifd_add: half bias addition in fixed point and final rounding (stages 7 to 11).
// Depends on ifd_pkg.
module ifd_add (
	input  logic                          clk,
	input  logic [ifd_pkg::ADD_STAGES-1:0] adv,
	input  logic [15:0]                   half_s6,
	input  logic [15:0]                   bias_s6,
	input  logic                          ub_s6,
	output logic [15:0]                   res_s11
);

	logic a_nan, b_nan, a_inf, b_inf;
	logic [15:0] spec_c;
	logic [40:0] fa, fb;
	logic signed [41:0] opa_s7, opb_s7;
	logic signed [41:0] sum_s8;
	logic [40:0] mag_s9, mag_s10;
	logic sgn_s9, sgn_s10;
	logic [6:0] lz_c, lz_s10;
	logic [15:0] ha_s7, ha_s8, ha_s9, ha_s10;
	logic [15:0] sph_s7, sph_s8, sph_s9, sph_s10;
	logic sp_s7, sp_s8, sp_s9, sp_s10;
	logic sz_s7, sz_s8, sz_s9, sz_s10;
	logic ub_s7, ub_s8, ub_s9, ub_s10;
	ifd_pkg::ifd_num_t n_c;

	always_comb begin
		a_nan = (half_s6[14:10] == 5'h1f) && (half_s6[9:0] != 10'h0);
		b_nan = (bias_s6[14:10] == 5'h1f) && (bias_s6[9:0] != 10'h0);
		a_inf = (half_s6[14:0] == 15'h7c00);
		b_inf = (bias_s6[14:0] == 15'h7c00);
		fa = ifd_pkg::half_fix(half_s6);
		fb = ifd_pkg::half_fix(bias_s6);
		if (a_nan || b_nan || (a_inf && b_inf && (half_s6[15] != bias_s6[15]))) begin
			spec_c = ifd_pkg::QNAN_H;
		end else if (a_inf) begin
			spec_c = half_s6;
		end else begin
			spec_c = bias_s6;
		end
	end

	// stage 7: to signed fixed point
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			opa_s7 <= half_s6[15] ? -$signed(42'(fa)) : $signed(42'(fa));
			opb_s7 <= bias_s6[15] ? -$signed(42'(fb)) : $signed(42'(fb));
			sp_s7 <= a_nan || b_nan || a_inf || b_inf;
			sph_s7 <= spec_c;
			sz_s7 <= half_s6[15] & bias_s6[15];
			ha_s7 <= half_s6;
			ub_s7 <= ub_s6;
		end
	end

	// stage 8: exact sum
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sum_s8 <= opa_s7 + opb_s7;
			sp_s8 <= sp_s7;
			sph_s8 <= sph_s7;
			sz_s8 <= sz_s7;
			ha_s8 <= ha_s7;
			ub_s8 <= ub_s7;
		end
	end

	// stage 9: magnitude
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mag_s9 <= sum_s8[41] ? 41'(-sum_s8) : 41'(sum_s8);
			sgn_s9 <= sum_s8[41];
			sp_s9 <= sp_s8;
			sph_s9 <= sph_s8;
			sz_s9 <= sz_s8;
			ha_s9 <= ha_s8;
			ub_s9 <= ub_s8;
		end
	end

	assign lz_c = ifd_pkg::lzc64({23'h0, mag_s9});

	// stage 10: leading zero count
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			mag_s10 <= mag_s9;
			lz_s10 <= lz_c;
			sgn_s10 <= sgn_s9;
			sp_s10 <= sp_s9;
			sph_s10 <= sph_s9;
			sz_s10 <= sz_s9;
			ha_s10 <= ha_s9;
			ub_s10 <= ub_s9;
		end
	end

	// stage 11: normalize, round to half, pick the result
	always_comb begin
		n_c = ifd_pkg::round_num(48'({mag_s10, 7'h0} << (lz_s10 - 7'd23)),
			ifd_pkg::EXP_W'(39 - int'(lz_s10)), 11, -14, 15);
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			if (!ub_s10) begin
				res_s11 <= ha_s10;
			end else if (sp_s10) begin
				res_s11 <= sph_s10;
			end else if (mag_s10 == 41'h0) begin
				res_s11 <= {sz_s10, 15'h0};
			end else begin
				res_s11 <= ifd_pkg::pack_half(sgn_s10, 1'b0, n_c);
			end
		end
	end

endmodule
